>>> hw/rtl/wgm_pkg.sv
`timescale 1ns / 1ps
// Package for the wildcard glob matcher: pattern byte codes, register indexes
// and the structs passed between the core and its position-set step logic.
// No dependencies.
package wgm_pkg;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_W       = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_index_t;

  // Pattern configuration as held by the core.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] low;
    logic [CFG_DATA_W-1:0] high;
    logic [LEN_W-1:0]      len;
  } pattern_cfg_t;

  // One text item held in the input register.
  typedef struct packed {
    logic [7:0] text_char;
    logic       has_char;
    logic       fresh;
  } step_item_t;

endpackage

>>> hw/rtl/wgm_step.sv
`timescale 1ns / 1ps
// Combinational update of the live pattern-position set for one text item.
// Depends on wgm_pkg for the pattern codes and the configuration struct.
module wgm_step #(
  parameter int PATTERN_CHARS = 16
) (
  input  wgm_pkg::pattern_cfg_t           cfg,
  input  wgm_pkg::step_item_t             item,
  input  logic [PATTERN_CHARS:0]          live,
  output logic [PATTERN_CHARS:0]          set_after,
  output logic                            matched
);

  localparam int NPOS   = PATTERN_CHARS + 1;
  localparam int LW     = $clog2(NPOS);
  localparam int LEVELS = $clog2(NPOS);

  // Star closure as a parallel prefix: position j+1 becomes live when j is
  // live and pattern byte j is a star.
  function automatic logic [NPOS-1:0] closure(input logic [NPOS-1:0] g0,
                                              input logic [PATTERN_CHARS-1:0] star);
    logic [NPOS-1:0] g;
    logic [NPOS-1:0] p;
    g = g0;
    p = {star, 1'b0};
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      g = g | (p & (g << (1 << lvl)));
      p = p & (p << (1 << lvl));
    end
    return g;
  endfunction

  logic [2*wgm_pkg::CFG_DATA_W-1:0] pat_bytes;
  logic [LW-1:0]                    alen;
  logic [PATTERN_CHARS-1:0]         star_v;
  logic [PATTERN_CHARS-1:0]         hit_v;
  logic [NPOS-1:0]                  start_set;
  logic [NPOS-1:0]                  live_eff;
  logic [NPOS-1:0]                  next_raw;

  assign pat_bytes = {cfg.high, cfg.low};
  assign alen = (cfg.len > wgm_pkg::LEN_W'(PATTERN_CHARS)) ? LW'(PATTERN_CHARS)
                                                           : LW'(cfg.len);

  always_comb begin
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      star_v[i] = (LW'(i) < alen) && (pat_bytes[i*8 +: 8] == wgm_pkg::STAR_BYTE);
      hit_v[i]  = (LW'(i) < alen) && !star_v[i] &&
                  ((pat_bytes[i*8 +: 8] == wgm_pkg::ANY_BYTE) ||
                   (pat_bytes[i*8 +: 8] == item.text_char));
    end
  end

  assign start_set = closure(NPOS'(1), star_v);
  assign live_eff  = item.fresh ? start_set : live;

  // A star keeps its position live; a literal or '?' hit moves one forward.
  assign next_raw = {1'b0, live_eff[PATTERN_CHARS-1:0] & star_v} |
                    {live_eff[PATTERN_CHARS-1:0] & hit_v, 1'b0};

  assign set_after = item.has_char ? closure(next_raw, star_v) : live_eff;
  assign matched   = set_after[alen];

endmodule

>>> hw/rtl/wildcard_glob_matcher_core.sv
`timescale 1ns / 1ps
// A last item passes the input register, then the output register, to reach m_tdata.
// Throughput: one text byte per cycle when not stalled; the position-set register closes
// the loop. The input stage only stalls while a verdict waits in the output register.
// Reset (rst, synchronous, active high) clears the pattern to empty and
// returns the position set to its start value. Depends on wgm_pkg and wgm_step.
module wildcard_glob_matcher_core #(
  parameter int PATTERN_CHARS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // Text stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] text_char
  input  logic [0:0]                         s_tuser,   // [0] has_char
  input  logic                               s_tlast,   // is_last
  // Verdict stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,   // [0] matched, [7:1] zero
  // Register writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wgm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                          in_valid;
  logic [7:0]                    in_char;
  logic                          in_has;
  logic                          in_last;
  logic [PATTERN_CHARS:0]        live;
  logic                          fresh;
  wgm_pkg::pattern_cfg_t         cfg;
  logic                          out_valid;
  logic                          out_matched;

  wgm_pkg::step_item_t           item;
  logic [PATTERN_CHARS:0]        set_after;
  logic                          matched;
  logic                          out_free;
  logic                          proc;
  logic                          cfg_we;

  assign out_free  = !out_valid || m_tready;
  assign proc      = in_valid && (!in_last || out_free);
  assign s_tready  = !in_valid || proc;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign item.text_char = in_char;
  assign item.has_char  = in_has;
  assign item.fresh     = fresh;

  wgm_step #(
    .PATTERN_CHARS(PATTERN_CHARS)
  ) u_step (
    .cfg       (cfg),
    .item      (item),
    .live      (live),
    .set_after (set_after),
    .matched   (matched)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_has  <= s_tuser[0];
      in_last <= s_tlast;
    end
  end

  // A write to a pattern register restarts the string; fresh makes the step logic use the
  // start set of the pattern now configured.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low  <= '0;
      cfg.high <= '0;
      cfg.len  <= '0;
      fresh    <= 1'b1;
    end else if (cfg_we) begin
      unique case (wgm_pkg::reg_index_t'(cfg_index))
        wgm_pkg::REG_PATTERN_LOW: begin
          cfg.low <= cfg_data;
          fresh   <= 1'b1;
        end
        wgm_pkg::REG_PATTERN_HIGH: begin
          cfg.high <= cfg_data;
          fresh    <= 1'b1;
        end
        wgm_pkg::REG_PATTERN_LENGTH: begin
          cfg.len <= cfg_data[wgm_pkg::LEN_W-1:0];
          fresh   <= 1'b1;
        end
        default: begin
        end
      endcase
    end else if (proc) begin
      fresh <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      live <= set_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last) begin
      out_matched <= matched;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_matched};

endmodule

>>> hw/rtl/wgm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the wildcard glob matcher core, bound to the top level.
// Depends only on the ports of wildcard_glob_matcher_core.
module wgm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // A verdict that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("verdict changed or dropped while stalled");

  // The input side only stalls behind a verdict the sink is holding off.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with no pending verdict");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:1] == 7'd0)
    else $error("verdict padding bits are not zero");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("verdict valid right after reset");

endmodule

bind wildcard_glob_matcher_core wgm_checker u_wgm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
